// ----- rtl/ahfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ahfd_pkg: shared types and constants of the ASCII hex frame decoder
// Holds the beat kinds, the end status codes, the register indexes, the
// character constants, the item and result structs, and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ahfd_pkg;

  // Kind of an input beat, carried in tuser
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // End status of a read
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BADHEX   = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  // Configuration register indexes
  localparam logic CFG_FRAME_CAPACITY = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS  = 1'b1;

  // Register reset values
  localparam logic [4:0]  CAPACITY_RESET = 5'd16;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd250;

  // Characters of interest
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [7:0] CHAR_UPF   = 8'h46;
  localparam logic [7:0] CHAR_LOA   = 8'h61;
  localparam logic [7:0] CHAR_LOF   = 8'h66;

  // One input item
  typedef struct packed {
    func_e      func;
    logic [7:0] rx_char;
  } item_t;

  // One result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       done_res;
    status_e    status;
    logic [4:0] frame_length;
  } result_t;

  // Decode one hex character: bit 4 flags a non-hex character
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] diff;
    logic [4:0] nib;
    diff = 8'd0;
    nib  = 5'h10;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      nib  = {1'b0, diff[3:0]};
    end else if (c >= CHAR_UPA && c <= CHAR_UPF) begin
      diff = c - CHAR_UPA + 8'd10;
      nib  = {1'b0, diff[3:0]};
    end else if (c >= CHAR_LOA && c <= CHAR_LOF) begin
      diff = c - CHAR_LOA + 8'd10;
      nib  = {1'b0, diff[3:0]};
    end
    return nib;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ahfd_core.sv -----
// ----------------------------------------------------------------------------
// ahfd_core: read state and per-item decode
// Holds the read state and works out, in one pass of logic, the next state
// and the result of the item presented on step_i.
// ----------------------------------------------------------------------------
`default_nettype none

module ahfd_core #(
  parameter int unsigned MAX_FRAME_BYTES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire ahfd_pkg::item_t  item_i,
  input  wire logic [4:0]       capacity_i,
  input  wire logic [15:0]      timeout_i,
  output logic                  res_valid_o,
  output ahfd_pkg::result_t     res_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned EW = (CW > 5) ? CW : 5;
  localparam logic [EW-1:0] MAX_EXT = EW'(MAX_FRAME_BYTES);

  logic          active_q, active_d;
  logic          colon_q, colon_d;
  logic          have_hi_q, have_hi_d;
  logic [7:0]    hi_char_q, hi_char_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   elapsed_q, elapsed_d;

  logic [EW-1:0] cnt_ext;
  logic [EW-1:0] cap_ext;
  logic [EW-1:0] cap_lim;
  logic [15:0]   elapsed_inc;
  logic [4:0]    hi_nib;
  logic [4:0]    lo_nib;

  // Clamp capacity and widen the count for compares and outputs
  assign cnt_ext     = EW'(cnt_q);
  assign cap_ext     = EW'(capacity_i);
  assign cap_lim     = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign hi_nib      = ahfd_pkg::hex_nibble(hi_char_q);
  assign lo_nib      = ahfd_pkg::hex_nibble(item_i.rx_char);

  // Next state and result of the current item
  always_comb begin
    active_d    = active_q;
    colon_d     = colon_q;
    have_hi_d   = have_hi_q;
    hi_char_d   = hi_char_q;
    cnt_d       = cnt_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      unique case (item_i.func)
        ahfd_pkg::FUNC_START: begin
          active_d  = 1'b1;
          colon_d   = 1'b0;
          have_hi_d = 1'b0;
          hi_char_d = 8'd0;
          cnt_d     = '0;
          elapsed_d = 16'd0;
        end
        ahfd_pkg::FUNC_TICK: begin
          if (active_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_i) begin
              active_d           = 1'b0;
              res_valid_o        = 1'b1;
              res_o.done_res     = 1'b1;
              res_o.status       = ahfd_pkg::ST_TIMEOUT;
              res_o.frame_length = cnt_ext[4:0];
            end
          end
        end
        ahfd_pkg::FUNC_CHAR: begin
          if (active_q) begin
            if (!colon_q) begin
              colon_d = (item_i.rx_char == ahfd_pkg::CHAR_COLON);
            end else if (item_i.rx_char == ahfd_pkg::CHAR_CR ||
                         item_i.rx_char == ahfd_pkg::CHAR_LF) begin
              // End of frame: a dangling high character is dropped
              active_d           = 1'b0;
              res_valid_o        = 1'b1;
              res_o.done_res     = 1'b1;
              res_o.status       = (cnt_q != '0) ? ahfd_pkg::ST_OK : ahfd_pkg::ST_EMPTY;
              res_o.frame_length = cnt_ext[4:0];
            end else if (!have_hi_q) begin
              hi_char_d = item_i.rx_char;
              have_hi_d = 1'b1;
            end else if (cnt_ext >= cap_lim) begin
              active_d           = 1'b0;
              res_valid_o        = 1'b1;
              res_o.done_res     = 1'b1;
              res_o.status       = ahfd_pkg::ST_OVERFLOW;
              res_o.frame_length = cnt_ext[4:0];
            end else if (hi_nib[4] || lo_nib[4]) begin
              active_d           = 1'b0;
              res_valid_o        = 1'b1;
              res_o.done_res     = 1'b1;
              res_o.status       = ahfd_pkg::ST_BADHEX;
              res_o.frame_length = cnt_ext[4:0];
            end else begin
              res_valid_o      = 1'b1;
              res_o.byte_valid = 1'b1;
              res_o.data_byte  = {hi_nib[3:0], lo_nib[3:0]};
              res_o.byte_index = cnt_ext[3:0];
              cnt_d            = cnt_q + 1'b1;
              have_hi_d        = 1'b0;
            end
          end
        end
        default: begin
          // unused kind: drop the beat
        end
      endcase
    end
  end

  // Hold the read state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      colon_q   <= 1'b0;
      have_hi_q <= 1'b0;
      hi_char_q <= 8'd0;
      cnt_q     <= '0;
      elapsed_q <= 16'd0;
    end else begin
      active_q  <= active_d;
      colon_q   <= colon_d;
      have_hi_q <= have_hi_d;
      hi_char_q <= hi_char_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef SYNTHESIS
  a_res_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> active_q)
    else $error("result produced while no read is active");

  a_res_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.byte_valid ^ res_o.done_res))
    else $error("result is neither a byte nor an end, or both");

  a_end_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.done_res) |=> !active_q)
    else $error("read still active after its end result");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= MAX_EXT)
    else $error("byte count beyond the frame maximum");
`endif

endmodule

`default_nettype wire

// ----- rtl/ascii_hex_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// ascii_hex_frame_decoder: ASCII hex frame decoder with stream ports
// Input register, decode core and result register with stream handshakes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave beats carry one item each: tuser gives the kind (start, character,
//   millisecond tick) and tdata the received character. A start arms a read;
//   after ':' each hex pair gives one byte beat on the master side, and CR,
//   LF, overflow, a bad pair or timeout gives one end beat with status and
//   length. Beats that produce nothing give no master beat.
//   An accepted item waits in the input register; its result loads into the
//   result register once that register frees, and is then offered on the
//   master side. Throughput: one item per cycle while the master side takes
//   its beats, set by the single pass of decode logic between the registers.
//   Stall: while a master beat waits, the input register still takes one more
//   item; further slave beats wait until the master side takes its beat.
//   Reset: the read is disarmed, both registers are empty, capacity is 16 and
//   timeout 250 ticks. The user must write registers through cfg_* only while
//   idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_hex_frame_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  // item stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_char
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] data_byte, [11:8] byte_index,
                                           // [14:12] status, [19:15] frame_length
  output logic [1:0]       m_axis_tuser    // [0] byte_valid, [1] done_res
);

  logic              in_valid_q, in_valid_d;
  ahfd_pkg::item_t   item_q, item_d;
  logic              out_valid_q, out_valid_d;
  ahfd_pkg::result_t out_q, out_d;
  logic [4:0]        cap_q, cap_d;
  logic [15:0]       tmo_q, tmo_d;

  logic              advance;
  logic              s_accept;
  logic              step;
  logic              res_valid;
  ahfd_pkg::result_t res;

  // Handshake: the result register frees when empty or taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign step          = in_valid_q && advance;

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (s_accept) begin
      in_valid_d     = 1'b1;
      item_d.func    = ahfd_pkg::func_e'(s_axis_tuser);
      item_d.rx_char = s_axis_tdata;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  // Configuration registers
  always_comb begin
    cap_d = cap_q;
    tmo_d = tmo_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ahfd_pkg::CFG_FRAME_CAPACITY: cap_d = cfg_wdata_i[4:0];
        ahfd_pkg::CFG_TIMEOUT_TICKS:  tmo_d = cfg_wdata_i;
        default:                      cap_d = cap_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= ahfd_pkg::CAPACITY_RESET;
      tmo_q       <= ahfd_pkg::TIMEOUT_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cap_q       <= cap_d;
      tmo_q       <= tmo_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  ahfd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .capacity_i  (cap_q),
    .timeout_i   (tmo_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.frame_length, 3'(out_q.status),
                          out_q.byte_index, out_q.data_byte};
  assign m_axis_tuser  = {out_q.done_res, out_q.byte_valid};

endmodule

`default_nettype wire

// ----- bench/ascii_hex_frame_decoder_test.sv -----
// ----------------------------------------------------------------------------
// ascii_hex_frame_decoder_test: stream-level test of the ASCII hex decoder
// Drives start, character and tick beats into the slave port and checks each
// master beat against an in-bench decoder model. The run covers directed frames,
// error ends, capacity and timeout settings, a long receiver hold-off, and
// random frames under several idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_hex_frame_decoder_test;

  localparam int               FRAME_BYTES_MAX = 16;
  localparam int               STALL_LIMIT     = 3000;
  localparam int               DRAIN_CYCLES    = 4;
  localparam int               PHASE_BEATS     = 56;
  localparam logic [1:0]       FUNC_UNUSED     = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_char
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] data_byte, [11:8] byte_index,
                               // [14:12] status, [19:15] frame_length
  logic [1:0]  m_axis_tuser;   // [0] byte_valid, [1] done_res

  // Decoder model state and its copy of the registers
  logic [4:0]  mdl_capacity;
  logic [15:0] mdl_timeout;
  logic        mdl_armed;
  logic        mdl_colon_seen;
  logic        mdl_nibble_held;
  logic [7:0]  mdl_high_char;
  logic [4:0]  mdl_byte_count;
  logic [15:0] mdl_ticks;

  ahfd_pkg::result_t expected_results[$];
  int          mismatches;
  int          beats_sent;
  int          stall_cycles;
  int          src_idle_pct;
  int          snk_idle_pct;
  int          hold_cycles;

  ascii_hex_frame_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Value of a hex character, or -1 for anything else
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= ahfd_pkg::CHAR_ZERO && c <= ahfd_pkg::CHAR_NINE)
      return int'(c) - int'(ahfd_pkg::CHAR_ZERO);
    if (c >= ahfd_pkg::CHAR_UPA && c <= ahfd_pkg::CHAR_UPF)
      return int'(c) - int'(ahfd_pkg::CHAR_UPA) + 10;
    if (c >= ahfd_pkg::CHAR_LOA && c <= ahfd_pkg::CHAR_LOF)
      return int'(c) - int'(ahfd_pkg::CHAR_LOA) + 10;
    return -1;
  endfunction

  task automatic clear_frame();
    mdl_colon_seen  = 1'b0;
    mdl_nibble_held = 1'b0;
    mdl_high_char   = 8'd0;
    mdl_byte_count  = 5'd0;
    mdl_ticks       = 16'd0;
  endtask

  // Close the read and queue its end beat
  task automatic end_frame(input ahfd_pkg::status_e st);
    ahfd_pkg::result_t r;
    r              = '0;
    r.done_res     = 1'b1;
    r.status       = st;
    r.frame_length = mdl_byte_count;
    expected_results.push_back(r);
    mdl_armed = 1'b0;
  endtask

  // Advance the model by one accepted beat and queue what it gives out
  task automatic decode_beat(input logic [1:0] func, input logic [7:0] ch);
    ahfd_pkg::result_t r;
    int      lim;
    int      hi;
    int      lo;
    r = '0;
    if (func == ahfd_pkg::FUNC_START) begin
      clear_frame();
      mdl_armed = 1'b1;
    end else if (mdl_armed && func == ahfd_pkg::FUNC_TICK) begin
      if (mdl_ticks != 16'hFFFF) mdl_ticks++;
      if (mdl_ticks >= mdl_timeout) end_frame(ahfd_pkg::ST_TIMEOUT);
    end else if (mdl_armed && func == ahfd_pkg::FUNC_CHAR) begin
      if (!mdl_colon_seen) begin
        mdl_colon_seen = (ch == ahfd_pkg::CHAR_COLON);
      end else if (ch == ahfd_pkg::CHAR_CR || ch == ahfd_pkg::CHAR_LF) begin
        end_frame(mdl_byte_count > 0 ? ahfd_pkg::ST_OK : ahfd_pkg::ST_EMPTY);
      end else if (!mdl_nibble_held) begin
        mdl_high_char   = ch;
        mdl_nibble_held = 1'b1;
      end else begin
        // capacity is checked before the pair is looked at
        lim = (mdl_capacity > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : int'(mdl_capacity);
        hi  = hex_digit(mdl_high_char);
        lo  = hex_digit(ch);
        if (mdl_byte_count >= lim) begin
          end_frame(ahfd_pkg::ST_OVERFLOW);
        end else if (hi < 0 || lo < 0) begin
          end_frame(ahfd_pkg::ST_BADHEX);
        end else begin
          r.byte_valid = 1'b1;
          r.data_byte  = 8'((hi << 4) | lo);
          r.byte_index = mdl_byte_count[3:0];
          expected_results.push_back(r);
          mdl_byte_count++;
          mdl_nibble_held = 1'b0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each master beat with the oldest expected result
  always @(posedge clk_i) begin
    ahfd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
        check_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
        check_field("byte_index", want.byte_index, m_axis_tdata[11:8]);
        check_field("done_res", want.done_res, m_axis_tuser[1]);
        check_field("status", want.status, m_axis_tdata[14:12]);
        check_field("frame_length", want.frame_length, m_axis_tdata[19:15]);
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat, with random gaps ahead of it; returns at a falling edge
  task automatic send_item(input logic [1:0] func, input logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= ch;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_beat(func, ch);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ahfd_pkg::FUNC_CHAR, s[i]);
  endtask

  task automatic send_start();
    send_item(ahfd_pkg::FUNC_START, 8'($urandom));
  endtask

  task automatic send_tick();
    send_item(ahfd_pkg::FUNC_TICK, 8'($urandom));
  endtask

  function automatic logic [7:0] random_hex_char();
    case ($urandom_range(2))
      0:       return ahfd_pkg::CHAR_ZERO + 8'($urandom_range(9));
      1:       return ahfd_pkg::CHAR_UPA + 8'($urandom_range(5));
      default: return ahfd_pkg::CHAR_LOA + 8'($urandom_range(5));
    endcase
  endfunction

  // Mostly hex, now and then any byte at all
  function automatic logic [7:0] frame_char();
    if ($urandom_range(99) < 5) return 8'($urandom);
    return random_hex_char();
  endfunction

  // Hold the sender until every result is in, then let the pipeline empty
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one register while idle and mirror it in the model
  task automatic write_reg(input logic addr, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (addr == ahfd_pkg::CFG_FRAME_CAPACITY) mdl_capacity = value[4:0];
    else mdl_timeout = value;
  endtask

  task automatic set_capacity(input logic [4:0] cap);
    write_reg(ahfd_pkg::CFG_FRAME_CAPACITY, {11'($urandom), cap});
  endtask

  // One frame: start, optional junk, colon, pairs with stray ticks, an optional ending
  task automatic send_random_frame(input int max_pairs);
    int pairs;
    int pick;
    send_start();
    repeat ($urandom_range(2)) send_item(ahfd_pkg::FUNC_CHAR, 8'($urandom));
    send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_COLON);
    pairs = $urandom_range(max_pairs);
    for (int k = 0; k < pairs; k++) begin
      if ($urandom_range(9) == 0) send_tick();
      send_item(ahfd_pkg::FUNC_CHAR, frame_char());
      send_item(ahfd_pkg::FUNC_CHAR, frame_char());
    end
    pick = $urandom_range(99);
    if (pick >= 80 && pick < 90) send_item(ahfd_pkg::FUNC_CHAR, random_hex_char());
    if (pick < 40 || (pick >= 80 && pick < 85))
      send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_CR);
    else if (pick < 90)
      send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_LF);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Well-formed frames at the reset settings
  task automatic test_frame_decode();
    send_start();
    send_text("x:00FFa59cBe\r");
    send_start();
    send_text(":\n");
    send_start();
    send_text(":123\r");
  endtask

  // Bad pairs, beats while disarmed, unused kind, restart mid-read
  task automatic test_frame_errors();
    send_start();
    send_text(":G0");
    send_text("5");
    send_tick();
    send_item(FUNC_UNUSED, 8'hA5);
    send_start();
    send_text(":1");
    send_start();
    send_text(":0g");
    send_start();
    send_text(":A@");
    send_start();
    send_text(":/`:\n");
  endtask

  // Capacity zero, one, above the maximum, and back to the top value
  task automatic test_capacity_limits();
    wait_drained();
    set_capacity(5'd0);
    send_start();
    send_text(":12");
    wait_drained();
    set_capacity(5'd1);
    send_start();
    send_text(":12zz");
    wait_drained();
    set_capacity(5'd31);
    send_start();
    send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_COLON);
    repeat (FRAME_BYTES_MAX + 1) begin
      send_item(ahfd_pkg::FUNC_CHAR, random_hex_char());
      send_item(ahfd_pkg::FUNC_CHAR, random_hex_char());
    end
    wait_drained();
    set_capacity(5'd16);
  endtask

  // Timeout zero, one, a few ticks, and the largest value
  task automatic test_timeout_limits();
    wait_drained();
    write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd0);
    send_start();
    send_tick();
    wait_drained();
    write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd1);
    send_start();
    send_text(":12");
    send_tick();
    wait_drained();
    write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd3);
    send_start();
    send_tick();
    send_tick();
    send_text(":");
    send_tick();
    wait_drained();
    write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
    send_start();
    send_tick();
    send_text(":7e\n");
    wait_drained();
    write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, ahfd_pkg::TIMEOUT_RESET);
  endtask

  // Long receiver hold-off while a full frame is offered, then drain
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_cycles  = 300;
    send_start();
    send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_COLON);
    repeat (FRAME_BYTES_MAX) begin
      send_item(ahfd_pkg::FUNC_CHAR, random_hex_char());
      send_item(ahfd_pkg::FUNC_CHAR, random_hex_char());
    end
    send_item(ahfd_pkg::FUNC_CHAR, ahfd_pkg::CHAR_LF);
    wait_drained();
  endtask

  // Random frames and noise over several settings and idling mixes
  task automatic test_random_frames();
    int phase_end;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          set_capacity(5'd16);
          write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd250);
        end
        1: begin
          set_capacity(5'd0);
          write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
        end
        2: begin
          set_capacity(5'd1);
          write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd1);
        end
        3: begin
          set_capacity(5'd31);
          write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'd0);
        end
        default: begin
          set_capacity(5'($urandom_range(2, 16)));
          write_reg(ahfd_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(4, 40)));
        end
      endcase
      case (phase % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 46; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 46; end
        default: begin src_idle_pct = 34; snk_idle_pct = 34; end
      endcase
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) begin
        if ($urandom_range(9) == 0)
          send_item(2'($urandom_range(3)), 8'($urandom));
        else if ($urandom_range(7) == 0)
          send_random_frame(FRAME_BYTES_MAX + 2);
        else
          send_random_frame(5);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = 1'b0;
    cfg_wdata_i   = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 2'd0;
    mismatches    = 0;
    beats_sent    = 0;
    stall_cycles  = 0;
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    hold_cycles   = 0;
    mdl_capacity  = ahfd_pkg::CAPACITY_RESET;
    mdl_timeout   = ahfd_pkg::TIMEOUT_RESET;
    mdl_armed     = 1'b0;
    clear_frame();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_frame_decode();
    test_frame_errors();
    test_capacity_limits();
    test_timeout_limits();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
